### hw/rtl/xtea_pkg.sv
// Shared constants, codes and control types for the XTEA CBC decrypt block.
`default_nettype none

package xtea_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned ROUND_W   = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0]  XTEA_DELTA    = 32'h9E37_79B9;
  localparam logic [WORD_W-1:0]  CHAIN_IV      = 32'h5555_5555;
  localparam logic [ROUND_W-1:0] MAX_ROUNDS    = 7'd64;
  localparam logic [ROUND_W-1:0] ROUNDS_RESET  = 7'd32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // take the accepted item, set up sum and counter
    logic step;    // run one XTEA cycle (two half-rounds)
    logic finish;  // chain XOR into the output register, advance the chain
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;  // no cycles left for the current item
  } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/xtea_in_if.sv
// Ciphertext input channel: valid/ready handshake with one 64-bit block per item.
`default_nettype none

interface xtea_in_if
  import xtea_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] block_lo;
  logic [WORD_W-1:0] block_hi;
  logic              restart;

  modport source (output valid, output block_lo, output block_hi, output restart,
                  input ready);
  modport sink   (input valid, input block_lo, input block_hi, input restart,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/xtea_out_if.sv
// Plaintext output channel: valid/ready handshake with one 64-bit block per item.
`default_nettype none

interface xtea_out_if
  import xtea_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] plain_lo;
  logic [WORD_W-1:0] plain_hi;

  modport source (output valid, output plain_lo, output plain_hi, input ready);
  modport sink   (input valid, input plain_lo, input plain_hi, output ready);
endinterface

`default_nettype wire

### hw/rtl/xtea_cfg_if.sv
// Configuration write channel: register index and write data with valid/ready.
`default_nettype none

interface xtea_cfg_if
  import xtea_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hw/rtl/xtea_ctrl.sv
// Controller: sequences load, rounds and finish for one item at a time.
`default_nettype none

module xtea_ctrl
  import xtea_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  output dp_cmd_t         cmd,
  input  wire dp_status_t status
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  // Output register is free if empty or being drained this cycle
  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!status.cnt_zero) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    if (cmd.finish) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

`ifndef SYNTHESIS
  // A finished item never overwrites one still waiting at the output
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("finish while output register is occupied");

  // A finished item shows up at the output on the next cycle
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("finished item not presented");

  // An accepted item is always followed by the round phase
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_RUN && !in_ready))
    else $error("accepted item did not start rounds");
`endif

endmodule

`default_nettype wire

### hw/rtl/xtea_dp.sv
// Datapath: config registers, iterative XTEA round unit, CBC chain and output register.
`default_nettype none

module xtea_dp
  import xtea_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  // configuration writes
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [WORD_W-1:0]    cfg_data,
  // input item
  input  wire logic [WORD_W-1:0]    block_lo,
  input  wire logic [WORD_W-1:0]    block_hi,
  input  wire logic                 restart,
  // output item
  output logic      [WORD_W-1:0]    plain_lo,
  output logic      [WORD_W-1:0]    plain_hi,
  // control
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status
);

  logic [WORD_W-1:0]  key_w0;
  logic [WORD_W-1:0]  key_w1;
  logic [WORD_W-1:0]  key_w2;
  logic [WORD_W-1:0]  key_w3;
  logic [ROUND_W-1:0] round_count;

  logic [WORD_W-1:0]  v0;
  logic [WORD_W-1:0]  v1;
  logic [WORD_W-1:0]  sum;
  logic [ROUND_W-1:0] cnt;
  logic [WORD_W-1:0]  cipher_lo;
  logic [WORD_W-1:0]  cipher_hi;
  logic [WORD_W-1:0]  chain_lo;
  logic [WORD_W-1:0]  chain_hi;

  logic [ROUND_W-1:0] n_sat;
  logic [WORD_W-1:0]  sum_mid;
  logic [WORD_W-1:0]  v1_next;
  logic [WORD_W-1:0]  v0_next;

  function automatic logic [WORD_W-1:0] mix(input logic [WORD_W-1:0] v);
    mix = ((v << 4) ^ (v >> 5)) + v;
  endfunction

  function automatic logic [WORD_W-1:0] key_pick(
    input logic [1:0]        sel,
    input logic [WORD_W-1:0] k0,
    input logic [WORD_W-1:0] k1,
    input logic [WORD_W-1:0] k2,
    input logic [WORD_W-1:0] k3
  );
    case (sel)
      2'd0:    key_pick = k0;
      2'd1:    key_pick = k1;
      2'd2:    key_pick = k2;
      default: key_pick = k3;
    endcase
  endfunction

  // Round counts above the maximum saturate
  assign n_sat = (round_count > MAX_ROUNDS) ? MAX_ROUNDS : round_count;

  // One XTEA cycle: upper half-round, sum step, lower half-round
  always_comb begin
    sum_mid = sum - XTEA_DELTA;
    v1_next = v1 - (mix(v0) ^ (sum + key_pick(sum[12:11], key_w0, key_w1, key_w2, key_w3)));
    v0_next = v0 - (mix(v1_next) ^
              (sum_mid + key_pick(sum_mid[1:0], key_w0, key_w1, key_w2, key_w3)));
  end

  assign status.cnt_zero = (cnt == '0);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_w0      <= '0;
      key_w1      <= '0;
      key_w2      <= '0;
      key_w3      <= '0;
      round_count <= ROUNDS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY0:   key_w0      <= cfg_data;
        REG_KEY1:   key_w1      <= cfg_data;
        REG_KEY2:   key_w2      <= cfg_data;
        REG_KEY3:   key_w3      <= cfg_data;
        REG_ROUNDS: round_count <= cfg_data[ROUND_W-1:0];
        default:    ;
      endcase
    end
  end

  // Round counter and CBC chain
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      chain_lo <= CHAIN_IV;
      chain_hi <= CHAIN_IV;
    end else begin
      if (cmd.load) begin
        cnt <= n_sat;
      end else if (cmd.step) begin
        cnt <= cnt - ROUND_W'(1);
      end
      if (cmd.load && restart) begin
        chain_lo <= CHAIN_IV;
        chain_hi <= CHAIN_IV;
      end else if (cmd.finish) begin
        chain_lo <= cipher_lo;
        chain_hi <= cipher_hi;
      end
    end
  end

  // Working words, sum and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      v0        <= block_lo;
      v1        <= block_hi;
      cipher_lo <= block_lo;
      cipher_hi <= block_hi;
      sum       <= WORD_W'(XTEA_DELTA * WORD_W'(n_sat));
    end else if (cmd.step) begin
      v0  <= v0_next;
      v1  <= v1_next;
      sum <= sum_mid;
    end
    if (cmd.finish) begin
      plain_lo <= v0 ^ chain_lo;
      plain_hi <= v1 ^ chain_hi;
    end
  end

`ifndef SYNTHESIS
  // Rounds never run past the loaded count
  a_step_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !status.cnt_zero)
    else $error("round step with no cycles left");

  // Counter starts at the saturated round count
  a_load_count: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (cnt == $past(n_sat)))
    else $error("round counter loaded with wrong count");
`endif

endmodule

`default_nettype wire

### hw/rtl/xtea_cbc_decrypt.sv
// XTEA decryption in CBC mode, one 64-bit block per item.
// Each accepted item is loaded, stepped through its round count (max 64) and then
//   finished into the output register once free; no new item is taken until then.
//   The single round unit runs one XTEA cycle (two half-rounds) per clock.
// Reset (rst, synchronous): keys cleared, round count 32, chain words 0x55555555.
`default_nettype none

module xtea_cbc_decrypt
  import xtea_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst,
  xtea_cfg_if.sink     cfg,
  xtea_in_if.sink      blk_in,
  xtea_out_if.source   blk_out
);

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // Config writes are taken at any time
  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid;

  xtea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (blk_in.valid),
    .in_ready  (blk_in.ready),
    .out_valid (blk_out.valid),
    .out_ready (blk_out.ready),
    .cmd       (cmd),
    .status    (status)
  );

  xtea_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .block_lo  (blk_in.block_lo),
    .block_hi  (blk_in.block_hi),
    .restart   (blk_in.restart),
    .plain_lo  (blk_out.plain_lo),
    .plain_hi  (blk_out.plain_hi),
    .cmd       (cmd),
    .status    (status)
  );

endmodule

`default_nettype wire
